>>> hdl/sequential_search_key_table_assert.svh
// Assertion macros shared by the key table RTL.
// Both macros expect clk and rst in scope (rst is synchronous, active high).
`ifndef SEQUENTIAL_SEARCH_KEY_TABLE_ASSERT_SVH
`define SEQUENTIAL_SEARCH_KEY_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSTK_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SSTK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sstk_pkg.sv
// Shared types and codes for the sequential search key table.
// No dependencies; used by the interfaces, engine and top level.
package sstk_pkg;

  localparam int unsigned DEF_CAPACITY = 16;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_SEARCH = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_TOGGLE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        found_position;
    logic signed [KEY_W-1:0] key_out;
    logic [COUNT_W-1:0]      entry_count;
    logic                    was_inserted;
  } res_t;

endpackage

>>> hdl/sstk_if.sv
// Valid/ready channel interfaces for the key table request and response words.
// Depends on sstk_pkg for field widths.
interface sstk_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [sstk_pkg::OP_W-1:0]            op;
  logic signed [sstk_pkg::KEY_W-1:0]    key;
  logic [sstk_pkg::POS_W-1:0]           position;

  modport source (output valid, output op, output key, output position, input ready);
  modport sink   (input valid, input op, input key, input position, output ready);
endinterface

interface sstk_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [sstk_pkg::STATUS_W-1:0]        status;
  logic [sstk_pkg::POS_W-1:0]           found_position;
  logic signed [sstk_pkg::KEY_W-1:0]    key_out;
  logic [sstk_pkg::COUNT_W-1:0]         entry_count;
  logic                                 was_inserted;

  modport source (output valid, output status, output found_position, output key_out,
                  output entry_count, output was_inserted, input ready);
  modport sink   (input valid, input status, input found_position, input key_out,
                  input entry_count, input was_inserted, output ready);
endinterface

>>> hdl/sstk_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sstk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sstk_engine.sv
// Sequencer for the key table: scans, appends, closes gaps and reads, one entry a cycle.
// Depends on sstk_pkg, sstk_ram and the assertion macro header.
module sstk_engine #(
  parameter int unsigned CAPACITY = sstk_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sstk_pkg::req_t req,
  output logic          idle,
  input  logic          res_take,
  output logic          res_valid,
  output sstk_pkg::res_t res
);
  import sstk_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_READ, S_RDDAT, S_FIN
  } state_t;

  state_t             state;
  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [IDX_W-1:0]   pos_r;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic               pend;
  logic [IDX_W-1:0]   pidx;
  logic [STATUS_W-1:0] status_r;
  logic [IDX_W-1:0]   fpos_r;
  logic [KEY_W-1:0]   kout_r;
  logic               added_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [KEY_W-1:0]   ram_rdata;

  logic issue, match, last, scan_miss, full, add_op, pos_ok, shift_done;

  sstk_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    issue      = idx < count;
    match      = pend && (ram_rdata == key_r);
    last       = (CNT_W'(pidx) + CNT_W'(1)) == count;
    // a miss ends the scan after the last entry compares, or at once on an empty table
    scan_miss  = pend ? (!match && last) : !issue;
    full       = count == CAP_CNT;
    add_op     = (op_r == OP_INSERT) || (op_r == OP_TOGGLE);
    pos_ok     = CMP_W'(req.position) < CMP_W'(count);
    shift_done = (state == S_SHIFT) && !issue && !pend;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = key_r;
    ram_raddr = idx[IDX_W-1:0];
    case (state)
      S_SCAN: begin
        if (scan_miss && add_op && !full) begin
          ram_we = 1'b1;
        end
      end
      S_SHIFT: begin
        // entry read last cycle moves down one place
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pidx - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
      end
      S_READ: begin
        ram_raddr = pos_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r     <= req.op;
            key_r    <= req.key;
            pos_r    <= IDX_W'(req.position);
            idx      <= '0;
            pend     <= 1'b0;
            fpos_r   <= '0;
            kout_r   <= req.key;
            added_r  <= 1'b0;
            case (req.op)
              OP_SEARCH, OP_INSERT, OP_REMOVE, OP_TOGGLE: begin
                status_r <= ST_MISS;
                state    <= S_SCAN;
              end
              OP_READ: begin
                if (pos_ok) begin
                  status_r <= ST_MISS;
                  state    <= S_READ;
                end else begin
                  status_r <= ST_RANGE;
                  state    <= S_FIN;
                end
              end
              default: begin
                status_r <= ST_MISS;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            fpos_r <= pidx;
            case (op_r)
              OP_SEARCH: begin
                status_r <= ST_OK;
                state    <= S_FIN;
              end
              OP_INSERT: begin
                state <= S_FIN;
              end
              default: begin
                status_r <= ST_OK;
                idx      <= CNT_W'(pidx) + CNT_W'(1);
                pend     <= 1'b0;
                state    <= S_SHIFT;
              end
            endcase
          end else begin
            if (issue) begin
              idx  <= idx + CNT_W'(1);
              pidx <= idx[IDX_W-1:0];
            end
            pend <= issue;
            if (scan_miss) begin
              if (add_op) begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  status_r <= ST_OK;
                  fpos_r   <= count[IDX_W-1:0];
                  count    <= count + CNT_W'(1);
                  added_r  <= 1'b1;
                end
              end
              state <= S_FIN;
            end
          end
        end
        S_SHIFT: begin
          if (issue) begin
            idx  <= idx + CNT_W'(1);
            pidx <= idx[IDX_W-1:0];
          end
          pend <= issue;
          if (shift_done) begin
            count <= count - CNT_W'(1);
            state <= S_FIN;
          end
        end
        S_READ: begin
          state <= S_RDDAT;
        end
        S_RDDAT: begin
          kout_r   <= ram_rdata;
          status_r <= ST_OK;
          fpos_r   <= pos_r;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = state == S_IDLE;
  assign res_valid = state == S_FIN;

  always_comb begin
    res.status         = status_r;
    res.found_position = POS_W'(fpos_r);
    res.key_out        = kout_r;
    res.entry_count    = COUNT_W'(count);
    res.was_inserted   = added_r;
  end

`include "sequential_search_key_table_assert.svh"

  `SSTK_ASSERT_IMPL(a_count_cap, 1'b1, count <= CAP_CNT, "entry count above capacity")
  `SSTK_ASSERT_IMPL(a_we_state, ram_we, state == S_SCAN || state == S_SHIFT, "stray table write")
  `SSTK_ASSERT_NEXT(a_shift_dec, shift_done, count == $past(count) - CNT_W'(1), "no count drop")

endmodule

>>> hdl/sequential_search_key_table.sv
// Search, insert, remove and toggle scan to a match or the table's end; remove and toggle-remove
// then close the gap. Read passes an address state and a data state; an out-of-range position
// or unused op goes straight to the response. A request is taken only while the engine is idle;
// the scan and gap-closing shift walk the RAM one entry a cycle through its single read port.
// The next request is taken while a response waits. Reset clears the count; RAM is not cleared.
module sequential_search_key_table #(
  parameter int unsigned CAPACITY = sstk_pkg::DEF_CAPACITY
) (
  input logic        clk,
  input logic        rst,
  sstk_req_if.sink   req,
  sstk_rsp_if.source rsp
);
  import sstk_pkg::*;

  req_t req_word;
  res_t res_word;
  logic eng_idle;
  logic res_valid;
  logic res_take;
  logic start;

  assign req.ready = eng_idle;
  assign start     = req.valid && eng_idle;
  assign res_take  = !rsp.valid || rsp.ready;

  always_comb begin
    req_word.op       = req.op;
    req_word.key      = req.key;
    req_word.position = req.position;
  end

  sstk_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req_word),
    .idle     (eng_idle),
    .res_take (res_take),
    .res_valid(res_valid),
    .res      (res_word)
  );

  // response register frees the engine while the word waits downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp.status         <= res_word.status;
      rsp.found_position <= res_word.found_position;
      rsp.key_out        <= res_word.key_out;
      rsp.entry_count    <= res_word.entry_count;
      rsp.was_inserted   <= res_word.was_inserted;
    end
  end

endmodule
